>>> rtl/quality_context_model_index_assert.svh
// assertion macros for the quality context model index block
// expects clk and rst_n in the scope of each use
`ifndef QUALITY_CONTEXT_MODEL_INDEX_ASSERT_SVH
`define QUALITY_CONTEXT_MODEL_INDEX_ASSERT_SVH

// antecedent holds in the same cycle as the consequent
`define QCMI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define QCMI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/qcmi_pkg.sv
// shared types, constants and helpers of the quality context model index block
// no dependencies
package qcmi_pkg;

  localparam int MODEL_W  = 22;
  localparam int SYMBOL_W = 6;
  localparam int QUAL_W   = 6;
  localparam int BASE_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUALITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGNED_MODE = 2'd1;

  localparam logic [7:0] MIN_QUALITY_RST = 8'd33;

  // base letters and their codes
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_N = 8'h4e;

  localparam logic [BASE_W-1:0] BASE_A = 3'd0;
  localparam logic [BASE_W-1:0] BASE_T = 3'd1;
  localparam logic [BASE_W-1:0] BASE_C = 3'd2;
  localparam logic [BASE_W-1:0] BASE_G = 3'd3;
  localparam logic [BASE_W-1:0] BASE_N = 3'd4;

  typedef struct packed {
    logic [7:0] base_char;
    logic [7:0] raw_quality;
    logic       read_start;
    logic [1:0] mean_class;
  } in_item_t;

  typedef struct packed {
    logic [MODEL_W-1:0]  model_number;
    logic [SYMBOL_W-1:0] code_symbol;
    logic                last_request;
  } out_item_t;

  // partial model terms and symbols handed from the context stage to the emit stage
  typedef struct packed {
    logic [MODEL_W-1:0]  term_a;
    logic [MODEL_W-1:0]  term_b;
    logic [MODEL_W-1:0]  term_c;
    logic [MODEL_W-1:0]  mean_off;
    logic                escape;
    logic [SYMBOL_W-1:0] symbol;
    logic [QUAL_W-1:0]   quality;
  } terms_t;

  function automatic logic [BASE_W-1:0] base_code(input logic [7:0] c);
    logic [BASE_W-1:0] code;
    unique case (c)
      CHAR_T:  code = BASE_T;
      CHAR_C:  code = BASE_C;
      CHAR_G:  code = BASE_G;
      CHAR_N:  code = BASE_N;
      default: code = BASE_A;
    endcase
    return code;
  endfunction

  // shared escape model, four blocks up in aligned mode
  function automatic logic [MODEL_W-1:0] escape_model(input logic [MODEL_W-1:0] block,
                                                      input logic aligned);
    return aligned ? {block[MODEL_W-3:0], 2'b00} : block;
  endfunction

endpackage

>>> rtl/quality_context_model_index.sv
// top level of the quality context model index block: input register, config, stages
// depends on qcmi_pkg, qcmi_ctx, qcmi_emit and quality_context_model_index_assert.svh
`include "quality_context_model_index_assert.svh"

// Takes one base and quality byte per transfer and emits coding requests (model number,
// symbol) for a context-modelling quality coder. Items flow through an input register,
// a context stage that holds the read history, and the output register; the first
// request is valid once the input, context and output registers have each taken it. An
// item whose quality is above the escape threshold gives one request and the block
// sustains one item per cycle while out_ready is high; a low-quality item gives an escape
// request and then the quality in the shared escape model, both from the output register
// at one transfer per cycle while out_ready is high. Configuration (min_quality at index
// 0, aligned_mode at index 1) must be written only while idle, not enforced by the block.
module quality_context_model_index #(
  parameter int QUALITY_SYMBOLS = 38,
  parameter int TOP_SYMBOL      = 45
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  qcmi_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output qcmi_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qcmi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qcmi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import qcmi_pkg::*;

  localparam int S = QUALITY_SYMBOLS;
  localparam logic [MODEL_W-1:0] BLOCK = 22'(S * S * S * 16);

  logic [7:0] min_q_r;
  logic       aligned_r;
  logic       s0_valid_r;
  in_item_t   s0_item_r;
  logic       ctx_ready;
  logic       terms_valid;
  terms_t     terms;
  logic       terms_ready;
  logic [MODEL_W-1:0] esc_model_chk;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s0_valid_r || ctx_ready;
  assign esc_model_chk = escape_model(BLOCK, aligned_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_q_r   <= MIN_QUALITY_RST;
      aligned_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_QUALITY:  min_q_r   <= cfg_data;
        CFG_ALIGNED_MODE: aligned_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s0_valid_r <= 1'b1;
    end else if (ctx_ready) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s0_item_r <= in_data;
  end

  qcmi_ctx #(
    .QUALITY_SYMBOLS(QUALITY_SYMBOLS),
    .TOP_SYMBOL     (TOP_SYMBOL)
  ) u_ctx (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (s0_valid_r),
    .item        (s0_item_r),
    .item_ready  (ctx_ready),
    .min_quality (min_q_r),
    .aligned_mode(aligned_r),
    .terms_valid (terms_valid),
    .terms       (terms),
    .terms_ready (terms_ready)
  );

  qcmi_emit #(
    .QUALITY_SYMBOLS(QUALITY_SYMBOLS)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .terms_valid (terms_valid),
    .terms       (terms),
    .terms_ready (terms_ready),
    .aligned_mode(aligned_r),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_ready   (out_ready)
  );

  // an escape transfer is always followed by the quality in the escape model
  `QCMI_ASSERT_NXT(a_escape_follow, out_valid && out_ready && !out_data.last_request, out_valid && out_data.last_request && (out_data.model_number == esc_model_chk), "escape not followed by escape model request")
  `QCMI_ASSERT_IMP(a_escape_symbol, out_valid && !out_data.last_request, out_data.code_symbol == '0, "escape request with nonzero symbol")
  // the input register only blocks while it holds an item the context stage cannot take
  `QCMI_ASSERT_IMP(a_in_block, !in_ready, s0_valid_r && !ctx_ready, "input stalled with empty input register")

endmodule

>>> rtl/qcmi_ctx.sv
// context stage: quality normalisation, read history and model term selection
// depends on qcmi_pkg
module qcmi_ctx #(
  parameter int QUALITY_SYMBOLS = 38,
  parameter int TOP_SYMBOL      = 45
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  qcmi_pkg::in_item_t item,
  output logic               item_ready,
  input  logic [7:0]         min_quality,
  input  logic               aligned_mode,
  output logic               terms_valid,
  output qcmi_pkg::terms_t   terms,
  input  logic               terms_ready
);
  import qcmi_pkg::*;

  localparam int S   = QUALITY_SYMBOLS;
  localparam int THR = TOP_SYMBOL - QUALITY_SYMBOLS - 1;
  localparam logic [7:0]         QMAX   = 8'(TOP_SYMBOL - 1);
  localparam logic signed [7:0]  THR_S  = 8'(THR);
  localparam logic [MODEL_W-1:0] K_20   = 22'd20;
  localparam logic [MODEL_W-1:0] K_60   = 22'd60;
  localparam logic [MODEL_W-1:0] K_S20  = 22'(S * 20);
  localparam logic [MODEL_W-1:0] K_S60  = 22'(S * 60);
  localparam logic [MODEL_W-1:0] OFF_P1 = 22'd5;
  localparam logic [MODEL_W-1:0] OFF_P2 = 22'(5 + S * 20);
  localparam logic [MODEL_W-1:0] OFF_P3 = 22'(5 + S * 20 + S * S * 20);
  localparam logic [MODEL_W-1:0] BLOCK  = 22'(S * S * S * 16);

  logic [BASE_W-1:0] prev_base_r;
  logic [QUAL_W-1:0] qual_r [4];
  logic [2:0]        pos_r;
  logic              valid_r;
  terms_t            terms_r;

  logic [BASE_W-1:0]  j0, pb;
  logic [7:0]         diff;
  logic [QUAL_W-1:0]  qn, q1, q2, q3, q4, bmax;
  logic [2:0]         pos_eff;
  logic [4:0]         g1;
  logic [1:0]         cflag;
  logic               take;
  terms_t             terms_nxt;

  assign item_ready  = !valid_r || terms_ready;
  assign take        = item_valid && item_ready;
  assign terms_valid = valid_r;
  assign terms       = terms_r;

  always_comb begin
    j0   = base_code(item.base_char);
    diff = item.raw_quality - min_quality;
    if (item.raw_quality < min_quality) begin
      qn = '0;
    end else if (diff > QMAX) begin
      qn = QMAX[QUAL_W-1:0];
    end else begin
      qn = diff[QUAL_W-1:0];
    end

    // a read start sees an empty history
    if (item.read_start) begin
      pos_eff = '0;
      pb = '0;
      q1 = '0;
      q2 = '0;
      q3 = '0;
      q4 = '0;
    end else begin
      pos_eff = pos_r;
      pb = prev_base_r;
      q1 = qual_r[0];
      q2 = qual_r[1];
      q3 = qual_r[2];
      q4 = qual_r[3];
    end

    g1   = ({2'b00, j0} << 2) + {2'b00, j0} + {2'b00, pb};
    bmax = (q2 > q3) ? q2 : q3;
    // at position three the third-previous quality stands in for the fourth
    cflag = 2'd0;
    if (q2 == q3) cflag = 2'd1;
    if (pos_eff == 3'd3 || q3 == q4) cflag = 2'd2;

    terms_nxt.term_a = '0;
    terms_nxt.term_b = '0;
    terms_nxt.term_c = '0;
    if (j0 != BASE_N) begin
      case (pos_eff)
        3'd0: begin
          terms_nxt.term_c = {19'd0, j0} + 22'd1;
        end
        3'd1: begin
          terms_nxt.term_a = {16'd0, q1} * K_20;
          terms_nxt.term_c = {17'd0, g1} + OFF_P1;
        end
        3'd2: begin
          terms_nxt.term_a = {16'd0, q1} * K_S20;
          terms_nxt.term_b = {16'd0, q2} * K_20;
          terms_nxt.term_c = {17'd0, g1} + OFF_P2;
        end
        default: begin
          terms_nxt.term_a = {16'd0, q1} * K_S60;
          terms_nxt.term_b = {16'd0, bmax} * K_60;
          terms_nxt.term_c = {20'd0, cflag} * K_20 + {17'd0, g1} + OFF_P3;
        end
      endcase
    end
    terms_nxt.mean_off = aligned_mode ? {20'd0, item.mean_class} * BLOCK : '0;
    terms_nxt.escape   = $signed({2'b00, qn}) <= THR_S;
    terms_nxt.symbol   = 6'($signed({2'b00, qn}) - THR_S);
    terms_nxt.quality  = qn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      prev_base_r <= '0;
      pos_r       <= '0;
      for (int i = 0; i < 4; i++) qual_r[i] <= '0;
    end else begin
      if (take) begin
        valid_r     <= 1'b1;
        prev_base_r <= j0;
        qual_r[0]   <= qn;
        qual_r[1]   <= q1;
        qual_r[2]   <= q2;
        qual_r[3]   <= q3;
        if (pos_eff < 3'd4) pos_r <= pos_eff + 3'd1;
        else pos_r <= pos_eff;
      end else if (terms_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) terms_r <= terms_nxt;
  end

endmodule

>>> rtl/qcmi_emit.sv
// emit stage: final model sum in the output register, one or two requests per item
// depends on qcmi_pkg
module qcmi_emit #(
  parameter int QUALITY_SYMBOLS = 38
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                terms_valid,
  input  qcmi_pkg::terms_t    terms,
  output logic                terms_ready,
  input  logic                aligned_mode,
  output logic                out_valid,
  output qcmi_pkg::out_item_t out_data,
  input  logic                out_ready
);
  import qcmi_pkg::*;

  localparam int S = QUALITY_SYMBOLS;
  localparam logic [MODEL_W-1:0] BLOCK = 22'(S * S * S * 16);

  logic                valid_r;
  logic                phase_r;
  logic                esc_r;
  logic [MODEL_W-1:0]  model_r;
  logic [SYMBOL_W-1:0] sym_r;
  logic [QUAL_W-1:0]   qual_r;
  logic                last_beat;
  logic                load;

  assign last_beat   = !esc_r || phase_r;
  assign terms_ready = !valid_r || (out_ready && last_beat);
  assign load        = terms_valid && terms_ready;

  assign out_valid = valid_r;
  always_comb begin
    if (phase_r) begin
      out_data.model_number = escape_model(BLOCK, aligned_mode);
      out_data.code_symbol  = qual_r;
    end else begin
      out_data.model_number = model_r;
      out_data.code_symbol  = sym_r;
    end
    out_data.last_request = last_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      phase_r <= 1'b0;
    end else if (valid_r && out_ready) begin
      // first transfer of an escape moves on to the escape model
      if (last_beat) valid_r <= 1'b0;
      else phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      esc_r   <= terms.escape;
      model_r <= terms.term_a + terms.term_b + terms.term_c + terms.mean_off;
      sym_r   <= terms.escape ? '0 : terms.symbol;
      qual_r  <= terms.quality;
    end
  end

endmodule
